/* hw/rtl/bfbx_pkg.sv */
// ----------------------------------------------------------------------------
// bfbx_pkg: shared types and constants of the byte frame builder
// Request layout between front and back, queue sizing, register indexes.
// ----------------------------------------------------------------------------
package bfbx_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoAw + 1;
  // position of the next byte inside one request, up to six bytes
  localparam int unsigned SlotW     = 3;

  localparam logic [CfgIdxW-1:0] RegHeader = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFooter = 1'b1;

  localparam logic FuncStart = 1'b0;
  localparam logic FuncData  = 1'b1;

  localparam logic [SlotW-1:0] SlotFirst = 3'd0;
  localparam logic [SlotW-1:0] SlotHdr1  = 3'd1;
  localparam logic [SlotW-1:0] SlotHdr2  = 3'd2;
  localparam logic [SlotW-1:0] SlotHdr3  = 3'd3;
  localparam logic [SlotW-1:0] SlotCheck = 3'd4;
  localparam logic [SlotW-1:0] SlotFoot  = 3'd5;

  typedef enum logic [1:0] {
    CMD_MISUSE,
    CMD_START,
    CMD_DATA
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic             close;
    logic [ByteW-1:0] frame_type;
    logic [ByteW-1:0] payload_length;
    logic [ByteW-1:0] sequence_req;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] check;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* hw/rtl/bfbx_in_if.sv */
// ----------------------------------------------------------------------------
// bfbx_in_if: input item channel
// Valid/ready handshake carrying start and data items.
// ----------------------------------------------------------------------------
interface bfbx_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [bfbx_pkg::ByteW-1:0] frame_type;
  logic [bfbx_pkg::ByteW-1:0] sequence_req;
  logic [bfbx_pkg::ByteW-1:0] payload_length;
  logic [bfbx_pkg::ByteW-1:0] data_byte;

  modport source (
    output valid, func, frame_type, sequence_req, payload_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, func, frame_type, sequence_req, payload_length, data_byte,
    output ready
  );
endinterface

/* hw/rtl/bfbx_out_if.sv */
// ----------------------------------------------------------------------------
// bfbx_out_if: frame byte channel
// Valid/ready handshake carrying one frame byte and its flags.
// ----------------------------------------------------------------------------
interface bfbx_out_if;
  logic                      valid;
  logic                      ready;
  logic [bfbx_pkg::ByteW-1:0] frame_byte;
  logic                      frame_end;
  logic                      misuse;

  modport source (
    output valid, frame_byte, frame_end, misuse,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, frame_end, misuse,
    output ready
  );
endinterface

/* hw/rtl/bfbx_front.sv */
// ----------------------------------------------------------------------------
// bfbx_front: item classifier
// Tracks the open frame, checks item order and queues one request per item.
// ----------------------------------------------------------------------------
module bfbx_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bfbx_in_if.sink                in_i,
  input  bfbx_pkg::fifo_stat_t   stat_i,
  output logic                   push_o,
  output bfbx_pkg::req_t         req_o
);

  logic                       open_q, open_d;
  logic [bfbx_pkg::ByteW-1:0] left_q, left_d;
  logic [bfbx_pkg::ByteW-1:0] check_q, check_d;
  logic [bfbx_pkg::ByteW-1:0] seed;

  assign in_i.ready = !stat_i.full;
  assign push_o     = in_i.valid && !stat_i.full;
  assign seed       = in_i.frame_type ^ in_i.payload_length ^ in_i.sequence_req;

  always_comb begin
    open_d  = open_q;
    left_d  = left_q;
    check_d = check_q;

    req_o.cmd            = bfbx_pkg::CMD_MISUSE;
    req_o.close          = 1'b0;
    req_o.frame_type     = in_i.frame_type;
    req_o.payload_length = in_i.payload_length;
    req_o.sequence_req   = in_i.sequence_req;
    req_o.data_byte      = in_i.data_byte;
    req_o.check          = seed;

    if (in_i.func == bfbx_pkg::FuncStart) begin
      if (!open_q) begin
        req_o.cmd   = bfbx_pkg::CMD_START;
        req_o.close = (in_i.payload_length == '0);
        open_d      = (in_i.payload_length != '0);
        left_d      = in_i.payload_length;
        check_d     = seed;
      end
    end else if (open_q) begin
      req_o.cmd   = bfbx_pkg::CMD_DATA;
      req_o.check = check_q ^ in_i.data_byte;
      req_o.close = (left_q == bfbx_pkg::ByteW'(1));
      check_d     = check_q ^ in_i.data_byte;
      left_d      = left_q - bfbx_pkg::ByteW'(1);
      // last declared byte closes the frame
      if (left_q == bfbx_pkg::ByteW'(1)) begin
        open_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      left_q  <= '0;
      check_q <= '0;
    end else if (push_o) begin
      open_q  <= open_d;
      left_q  <= left_d;
      check_q <= check_d;
    end
  end

endmodule

/* hw/rtl/bfbx_fifo.sv */
// ----------------------------------------------------------------------------
// bfbx_fifo: request queue
// Short register queue that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module bfbx_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bfbx_pkg::req_t       req_i,
  input  logic                 pop_i,
  output bfbx_pkg::req_t       head_o,
  output bfbx_pkg::fifo_stat_t stat_o
);

  bfbx_pkg::req_t                 mem_q [bfbx_pkg::FifoDepth];
  logic [bfbx_pkg::FifoAw-1:0]    wr_q, rd_q;
  logic [bfbx_pkg::FifoCntW-1:0]  cnt_q;

  assign stat_o.full  = (cnt_q == bfbx_pkg::FifoCntW'(bfbx_pkg::FifoDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + bfbx_pkg::FifoAw'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + bfbx_pkg::FifoAw'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + bfbx_pkg::FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - bfbx_pkg::FifoCntW'(1);
      end
    end
  end

endmodule

/* hw/rtl/bfbx_back.sv */
// ----------------------------------------------------------------------------
// bfbx_back: frame serializer
// Walks the bytes of the head request into the output register, one a cycle while out_o is ready.
// ----------------------------------------------------------------------------
module bfbx_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfbx_pkg::req_t             head_i,
  input  bfbx_pkg::fifo_stat_t       stat_i,
  input  logic [bfbx_pkg::ByteW-1:0] header_i,
  input  logic [bfbx_pkg::ByteW-1:0] footer_i,
  output logic                       pop_o,
  bfbx_out_if.source                 out_o
);

  logic [bfbx_pkg::SlotW-1:0] slot_q;
  logic                       valid_q;
  logic [bfbx_pkg::ByteW-1:0] byte_q;
  logic                       end_q;
  logic                       misuse_q;

  logic [bfbx_pkg::ByteW-1:0] nxt_byte;
  logic                       nxt_end;
  logic                       nxt_misuse;
  logic                       nxt_last;
  logic                       load;

  assign load  = !stat_i.empty && (!valid_q || out_o.ready);
  assign pop_o = load && nxt_last;

  always_comb begin
    nxt_byte   = '0;
    nxt_end    = 1'b0;
    nxt_misuse = 1'b0;
    nxt_last   = 1'b1;
    case (head_i.cmd)
      bfbx_pkg::CMD_START: begin
        nxt_last = head_i.close ? (slot_q == bfbx_pkg::SlotFoot)
                                : (slot_q == bfbx_pkg::SlotHdr3);
        case (slot_q)
          bfbx_pkg::SlotFirst: nxt_byte = header_i;
          bfbx_pkg::SlotHdr1:  nxt_byte = head_i.frame_type;
          bfbx_pkg::SlotHdr2:  nxt_byte = head_i.payload_length;
          bfbx_pkg::SlotHdr3:  nxt_byte = head_i.sequence_req;
          bfbx_pkg::SlotCheck: nxt_byte = head_i.check;
          bfbx_pkg::SlotFoot: begin
            nxt_byte = footer_i;
            nxt_end  = 1'b1;
          end
          default: nxt_byte = '0;
        endcase
      end
      bfbx_pkg::CMD_DATA: begin
        // data, then check and footer when it closes; slots 0, 1, 2
        nxt_last = head_i.close ? (slot_q == bfbx_pkg::SlotHdr2)
                                : (slot_q == bfbx_pkg::SlotFirst);
        case (slot_q)
          bfbx_pkg::SlotFirst: nxt_byte = head_i.data_byte;
          bfbx_pkg::SlotHdr1:  nxt_byte = head_i.check;
          bfbx_pkg::SlotHdr2: begin
            nxt_byte = footer_i;
            nxt_end  = 1'b1;
          end
          default: nxt_byte = '0;
        endcase
      end
      default: begin
        nxt_misuse = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= bfbx_pkg::SlotFirst;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        slot_q  <= nxt_last ? bfbx_pkg::SlotFirst : slot_q + bfbx_pkg::SlotW'(1);
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= nxt_byte;
      end_q    <= nxt_end;
      misuse_q <= nxt_misuse;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.frame_byte = byte_q;
  assign out_o.frame_end  = end_q;
  assign out_o.misuse     = misuse_q;

endmodule

/* hw/rtl/byte_frame_builder_xor_unit.sv */
// ----------------------------------------------------------------------------
// byte_frame_builder_xor_unit: byte frame builder with XOR check byte
// Turns start and data items into a serialized frame byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries start items (func 0: type, sequence, length) and data items
//   (func 1: one payload byte). out_o gives one frame byte per transfer with
//   frame_end on the footer and misuse on an out-of-order item.
//   header_byte and footer_byte are written through cfg_we_i/cfg_idx_i/
//   cfg_wdata_i while the block is idle; the user ensures that, not the block.
// Path: an accepted item enters the request queue; its first byte is then
//   registered at out_o once the queue ahead is empty and out_o is free.
// Throughput: out_o moves one byte per cycle while out_o.ready is high and
//   a request waits. A data item gives 1 output byte (3 when it closes the
//   frame), a start item 4 (6 for an empty frame), a misuse item 1. in_i
//   takes one item per cycle while the four-entry request queue has room;
//   the output serializer sets the sustained rate.
// Reset: no frame open, queue and output empty, registers 0xAA and 0x55.
// Stall: when out_o.ready is low the output byte holds, the serializer waits
//   and in_i keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module byte_frame_builder_xor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bfbx_in_if.sink                       in_i,
  bfbx_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [bfbx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bfbx_pkg::ByteW-1:0]    cfg_wdata_i
);

  logic [bfbx_pkg::ByteW-1:0] header_q;
  logic [bfbx_pkg::ByteW-1:0] footer_q;
  logic                       push;
  logic                       pop;
  bfbx_pkg::req_t             req;
  bfbx_pkg::req_t             head;
  bfbx_pkg::fifo_stat_t       stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= 8'hAA;
      footer_q <= 8'h55;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfbx_pkg::RegHeader: header_q <= cfg_wdata_i;
        bfbx_pkg::RegFooter: footer_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bfbx_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push),
    .req_o  (req)
  );

  bfbx_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (req),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  bfbx_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .stat_i   (stat),
    .header_i (header_q),
    .footer_i (footer_q),
    .pop_o    (pop),
    .out_o    (out_o)
  );

`ifndef ASSERT_OFF
  a_misuse_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.misuse |-> out_o.frame_byte == '0 && !out_o.frame_end)
    else $error("misuse result carries a byte");

  a_end_is_footer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_end |-> out_o.frame_byte == footer_q && !out_o.misuse)
    else $error("frame end not on footer byte");

  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.full && stat.empty) && !(pop && stat.empty))
    else $error("request queue state broken");
`endif

endmodule

/* tb/tb_byte_frame_builder_xor_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_frame_builder_xor_unit: self-checking bench of the byte frame builder
// Drives start and data items with bursty timing against a stalling receiver.
// A scoreboard predicts every frame byte, including the XOR check byte and
// the misuse flags, and compares each output byte in order.
// ----------------------------------------------------------------------------
module tb_byte_frame_builder_xor_unit;
  import bfbx_pkg::*;

  localparam int unsigned QuietLimit  = 500;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic             func;
    logic [ByteW-1:0] frame_type;
    logic [ByteW-1:0] sequence_req;
    logic [ByteW-1:0] payload_length;
    logic [ByteW-1:0] data_byte;
  } frame_item_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             frame_end;
    logic             misuse;
  } frame_out_t;

  // Tracks the open frame and holds the bytes still owed by the block.
  class frame_scoreboard;
    logic [ByteW-1:0] header_byte;
    logic [ByteW-1:0] footer_byte;
    bit               frame_open;
    logic [ByteW-1:0] bytes_left;
    logic [ByteW-1:0] running_check;
    frame_out_t       owed_bytes[$];
    int unsigned      fail_count;

    function new();
      header_byte   = 8'hAA;
      footer_byte   = 8'h55;
      frame_open    = 1'b0;
      bytes_left    = '0;
      running_check = '0;
      fail_count    = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] value);
      if (idx == RegHeader) begin
        header_byte = value;
      end else if (idx == RegFooter) begin
        footer_byte = value;
      end
    endfunction

    function void owe(logic [ByteW-1:0] b, logic last, logic bad);
      frame_out_t r;
      r.frame_byte = b;
      r.frame_end  = last;
      r.misuse     = bad;
      owed_bytes.push_back(r);
    endfunction

    function void close_frame();
      owe(running_check, 1'b0, 1'b0);
      owe(footer_byte, 1'b1, 1'b0);
      frame_open = 1'b0;
      bytes_left = '0;
    endfunction

    function void note_request(frame_item_t it);
      if (it.func == FuncStart) begin
        if (frame_open) begin
          owe('0, 1'b0, 1'b1);
          return;
        end
        owe(header_byte, 1'b0, 1'b0);
        owe(it.frame_type, 1'b0, 1'b0);
        owe(it.payload_length, 1'b0, 1'b0);
        owe(it.sequence_req, 1'b0, 1'b0);
        running_check = it.frame_type ^ it.payload_length ^ it.sequence_req;
        bytes_left    = it.payload_length;
        frame_open    = 1'b1;
        if (it.payload_length == '0) close_frame();
        return;
      end
      if (!frame_open) begin
        owe('0, 1'b0, 1'b1);
        return;
      end
      owe(it.data_byte, 1'b0, 1'b0);
      running_check = running_check ^ it.data_byte;
      bytes_left    = bytes_left - 8'd1;
      if (bytes_left == '0) close_frame();
    endfunction

    function void note_failure(string msg);
      fail_count++;
      if (fail_count <= MaxReports) $display("%0t ns: %s", $realtime, msg);
    endfunction

    function void check_byte(frame_out_t got);
      frame_out_t want;
      if (owed_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h end %b misuse %b",
                               got.frame_byte, got.frame_end, got.misuse));
        return;
      end
      want = owed_bytes.pop_front();
      if (got.frame_byte !== want.frame_byte || got.frame_end !== want.frame_end ||
          got.misuse !== want.misuse) begin
        note_failure($sformatf(
          "mismatch: expected byte %02h end %b misuse %b, got byte %02h end %b misuse %b",
          want.frame_byte, want.frame_end, want.misuse,
          got.frame_byte, got.frame_end, got.misuse));
      end
    endfunction

    function void flag_leftovers();
      if (owed_bytes.size() != 0) begin
        note_failure($sformatf("%0d frame bytes never arrived", owed_bytes.size()));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [ByteW-1:0] cfg_wdata;

  bfbx_in_if  in_if ();
  bfbx_out_if out_if ();

  frame_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  byte_frame_builder_xor_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic frame_item_t make_item(logic func, logic [ByteW-1:0] ftype,
                                            logic [ByteW-1:0] seq, logic [ByteW-1:0] len,
                                            logic [ByteW-1:0] data);
    frame_item_t it;
    it.func           = func;
    it.frame_type     = ftype;
    it.sequence_req   = seq;
    it.payload_length = len;
    it.data_byte      = data;
    return it;
  endfunction

  // Send one request; bursts of back-to-back requests alternate with gaps.
  task automatic send_item(frame_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_if.valid          <= 1'b1;
    in_if.func           <= it.func;
    in_if.frame_type     <= it.frame_type;
    in_if.sequence_req   <= it.sequence_req;
    in_if.payload_length <= it.payload_length;
    in_if.data_byte      <= it.data_byte;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(it);
  endtask

  // Drop valid, wait for every owed byte, then let the pipeline settle.
  task automatic drain_frames();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.owed_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_frame_bytes(logic [ByteW-1:0] header, logic [ByteW-1:0] footer);
    drain_frames();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= RegHeader;
    cfg_wdata <= header;
    sb.set_register(RegHeader, header);
    @(negedge clk);
    cfg_idx   <= RegFooter;
    cfg_wdata <= footer;
    sb.set_register(RegFooter, footer);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, some out-of-order requests.
  task automatic run_random_frames(int unsigned count, bit with_long_frame);
    int unsigned sent;
    bit          long_pending;
    frame_item_t it;
    sent         = 0;
    long_pending = with_long_frame;
    while (sent < count || sb.frame_open) begin
      it = make_item(FuncData, ByteW'($urandom_range(0, 255)),
                     ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                     ByteW'($urandom_range(0, 255)));
      if (sb.frame_open) begin
        if (sent < count && $urandom_range(0, 19) == 0) it.func = FuncStart;
      end else if ($urandom_range(0, 6) != 0) begin
        it.func = FuncStart;
        if (long_pending && sent >= count / 2) begin
          it.payload_length = 8'h80;
          long_pending      = 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
          it.payload_length = ByteW'($urandom_range(7, 40));
        end else begin
          it.payload_length = ByteW'($urandom_range(0, 6));
        end
      end
      send_item(it);
      sent++;
    end
  endtask

  // Receiver: switch among always ready, random ready and long stalls.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    mode_left    = 0;
    stall_left   = 0;
    mode         = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
        0: begin
          out_if.ready <= 1'b1;
        end
        1: begin
          out_if.ready <= ($urandom_range(0, 9) < 7);
        end
        default: begin
          if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
          end else begin
            out_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // Check accepted bytes; end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_byte({out_if.frame_byte, out_if.frame_end, out_if.misuse});
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    frame_item_t directed[$];
    in_if.valid          = 1'b0;
    in_if.func           = FuncStart;
    in_if.frame_type     = '0;
    in_if.sequence_req   = '0;
    in_if.payload_length = '0;
    in_if.data_byte      = '0;
    cfg_we               = 1'b0;
    cfg_idx              = RegHeader;
    cfg_wdata            = '0;
    rst_n                = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // data with no frame open
    directed.push_back(make_item(FuncData, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // empty frames at both field extremes, then a three-byte frame
    directed.push_back(make_item(FuncStart, 8'h00, 8'h00, 8'h00, 8'hFF));
    directed.push_back(make_item(FuncStart, 8'hFF, 8'hFF, 8'h00, 8'h00));
    directed.push_back(make_item(FuncStart, 8'h5A, 8'hA5, 8'h03, 8'h00));
    // start while a frame is open
    directed.push_back(make_item(FuncStart, 8'h11, 8'h22, 8'h00, 8'h33));
    directed.push_back(make_item(FuncData, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    directed.push_back(make_item(FuncData, 8'h00, 8'h00, 8'h00, 8'hFF));
    directed.push_back(make_item(FuncData, 8'h00, 8'h00, 8'h00, 8'h80));
    directed.push_back(make_item(FuncData, 8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(make_item(FuncStart, 8'hC3, 8'h3C, 8'h01, 8'h00));
    directed.push_back(make_item(FuncData, 8'h00, 8'h00, 8'h00, 8'h7E));
    directed.push_back(make_item(FuncStart, 8'h80, 8'h01, 8'h02, 8'h00));
    directed.push_back(make_item(FuncData, 8'h00, 8'h00, 8'h00, 8'h01));
    directed.push_back(make_item(FuncData, 8'h00, 8'h00, 8'h00, 8'hFE));
    foreach (directed[i]) send_item(directed[i]);

    program_frame_bytes(8'h00, 8'hFF);
    run_random_frames(50, 1'b0);
    program_frame_bytes(8'hFF, 8'h00);
    run_random_frames(30, 1'b1);
    program_frame_bytes(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)));
    run_random_frames(50, 1'b0);
    drain_frames();

    sb.flag_leftovers();
    if (sb.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
